>>> hdl/rsb_pkg.sv
`default_nettype none

package rsb_pkg;

    // blend mode codes
    localparam logic [1:0] BLEND_OPAQUE = 2'd0;
    localparam logic [1:0] BLEND_AVG    = 2'd1;
    localparam logic [1:0] BLEND_ADD    = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_FOG_RED   = 2'd0;
    localparam logic [1:0] REG_FOG_GREEN = 2'd1;
    localparam logic [1:0] REG_FOG_BLUE  = 2'd2;

    // fog amount that means pure fog colour
    localparam logic [8:0] FOG_FULL = 9'd256;

    // load enables of the channel pipeline stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

    // 4x4 ordered dither matrix, row y, column x
    function automatic logic [3:0] bayer(input logic [1:0] y, input logic [1:0] x);
        logic [3:0] val;
        case ({y, x})
            4'h0: val = 4'd0;
            4'h1: val = 4'd8;
            4'h2: val = 4'd2;
            4'h3: val = 4'd10;
            4'h4: val = 4'd12;
            4'h5: val = 4'd4;
            4'h6: val = 4'd14;
            4'h7: val = 4'd6;
            4'h8: val = 4'd3;
            4'h9: val = 4'd11;
            4'ha: val = 4'd1;
            4'hb: val = 4'd9;
            4'hc: val = 4'd15;
            4'hd: val = 4'd7;
            4'he: val = 4'd13;
            default: val = 4'd5;
        endcase
        return val;
    endfunction

    // dither offset in 1/2048 steps: 128*B - 960, range -960..960
    function automatic logic signed [11:0] dither_offset(input logic [3:0] b);
        return $signed({1'b0, b, 7'b0}) - 12'sd960;
    endfunction

endpackage

`default_nettype wire

>>> hdl/rsb_shade_chan.sv
`default_nettype none

// One colour channel: shade multiply, fog lerp, dither, round and clamp.
// Three register stages; the result is valid in stage three.
module rsb_shade_chan #(
    parameter int SHADE_FRAC_BITS = 4
) (
    input  wire logic                    aclk,
    input  wire rsb_pkg::stage_en_t      en,
    input  wire logic [4:0]              base,
    input  wire logic [11:0]             shade,
    input  wire logic [4:0]              fog_color,
    input  wire logic [8:0]              fog_amt,    // already saturated to 256
    input  wire logic signed [11:0]      dith_off,   // zero when dither is off
    output logic [4:0]                   chan
);

    localparam int SHL = (SHADE_FRAC_BITS < 4) ? (4 - SHADE_FRAC_BITS) : 0;
    localparam int SHR = (SHADE_FRAC_BITS > 4) ? (SHADE_FRAC_BITS - 4) : 0;
    localparam int VW  = 17 + SHL;     // scaled product width
    localparam int MW  = VW + 9;       // product with fog complement
    localparam int FW  = VW + 10;      // lerp sum
    localparam int LW  = FW - 8;       // lerp result
    localparam int WW  = LW + 2;       // signed rounding value

    // stage 1 registers
    logic [16:0]        prod_reg;
    logic [4:0]         fogc_reg;
    logic [8:0]         famt_reg;
    logic signed [11:0] off1_reg;

    // stage 2 registers
    logic [MW-1:0]      mv_reg;
    logic [13:0]        mf_reg;
    logic signed [11:0] off2_reg;

    // stage 3 register
    logic [4:0]         chan_reg;

    logic [VW-1:0]      v_scaled;
    logic [FW-1:0]      lerp_sum;
    logic [LW-1:0]      lerp;
    logic signed [WW-1:0] w_val;
    logic [WW-12:0]     w_steps;
    logic [4:0]         chan_next;

    // stage 1: base times shade
    always_ff @(posedge aclk) begin
        if (en.s1) begin
            prod_reg <= 17'(base) * 17'(shade);
            fogc_reg <= fog_color;
            famt_reg <= fog_amt;
            off1_reg <= dith_off;
        end
    end

    // stage 2: scale to 1/2048 units, both lerp products
    assign v_scaled = (VW'(prod_reg) << SHL) >> SHR;

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            mv_reg   <= MW'(v_scaled) * MW'(rsb_pkg::FOG_FULL - famt_reg);
            mf_reg   <= 14'(fogc_reg) * 14'(famt_reg);
            off2_reg <= off1_reg;
        end
    end

    // stage 3: lerp sum, rounding bias, dither, clamp to 0..31
    assign lerp_sum = FW'(mv_reg) + FW'({mf_reg, 11'b0});
    assign lerp     = lerp_sum[FW-1:8];
    assign w_val    = $signed({2'b0, lerp}) + WW'(1024) + WW'(off2_reg);
    assign w_steps  = w_val[WW-2:11];

    always_comb begin
        if (w_val[WW-1]) begin
            chan_next = 5'd0;
        end else if (w_steps > (WW-11)'(31)) begin
            chan_next = 5'd31;
        end else begin
            chan_next = w_steps[4:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            chan_reg <= chan_next;
        end
    end

    assign chan = chan_reg;

endmodule

`default_nettype wire

>>> hdl/rgb555_fragment_shade_blend.sv
`default_nettype none

// Fragment colour back end for a 5:5:5 framebuffer.
// Input stream: one word per covered pixel (texel, shade, fog amount, dither
// coordinates, destination pixel, blend mode). Output stream: one word per
// input word, holding a write enable and the new pixel; a transparent texel
// gives write enable 0 and pixel 0.
// Fog colour comes from three 5-bit registers written through cfg_wr_en /
// cfg_index / cfg_data; write them only while no word is in flight.
// Four register stages (multiply, lerp products, round/clamp, blend), the
// first loaded at accept. Throughput: one word per cycle while m_axis_tready
// is high; every stage is a register with its own valid bit, so empty stages
// fill even while the output is stalled.
// When m_axis_tready is low the words hold in place and s_axis_tready drops
// once the pipeline is full; nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties the pipeline and clears the fog
// colour to black.
module rgb555_fragment_shade_blend #(
    parameter int SHADE_FRAC_BITS = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // texel[15:0], textured[16], shade_red[28:17], shade_green[40:29],
    // shade_blue[52:41], fog_amount[61:53], dither_on[62], x_low[64:63],
    // y_low[66:65], dest_pixel[81:67], blend_mode[83:82], zero[87:84]
    input  wire logic [87:0] s_axis_tdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // write_enable[0], pixel[15:1]
    output logic [15:0]      m_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [4:0]  cfg_data
);

    // input fields
    logic [15:0] in_texel;
    logic        in_textured;
    logic [11:0] in_shade_r, in_shade_g, in_shade_b;
    logic [8:0]  in_fog_amount;
    logic        in_dither_on;
    logic [1:0]  in_x_low, in_y_low;
    logic [14:0] in_dest;
    logic [1:0]  in_mode;

    assign in_texel      = s_axis_tdata[15:0];
    assign in_textured   = s_axis_tdata[16];
    assign in_shade_r    = s_axis_tdata[28:17];
    assign in_shade_g    = s_axis_tdata[40:29];
    assign in_shade_b    = s_axis_tdata[52:41];
    assign in_fog_amount = s_axis_tdata[61:53];
    assign in_dither_on  = s_axis_tdata[62];
    assign in_x_low      = s_axis_tdata[64:63];
    assign in_y_low      = s_axis_tdata[66:65];
    assign in_dest       = s_axis_tdata[81:67];
    assign in_mode       = s_axis_tdata[83:82];

    // fog colour registers
    logic [4:0] fog_r_reg, fog_g_reg, fog_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fog_r_reg <= 5'd0;
            fog_g_reg <= 5'd0;
            fog_b_reg <= 5'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                rsb_pkg::REG_FOG_RED:   fog_r_reg <= cfg_data;
                rsb_pkg::REG_FOG_GREEN: fog_g_reg <= cfg_data;
                rsb_pkg::REG_FOG_BLUE:  fog_b_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage valids and load enables; a stage loads when empty or draining
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;
    rsb_pkg::stage_en_t chan_en;

    assign en4 = !v4_reg || m_axis_tready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_axis_tready = en1;
    assign chan_en = '{s1: en1, s2: en2, s3: en3};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_axis_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // input decode: base colour, transparency, fog saturation, dither offset
    logic [4:0]         base_r, base_g, base_b;
    logic               opaque;
    logic [8:0]         fog_sat;
    logic signed [11:0] dith_off;

    assign opaque   = !in_textured || in_texel[15];
    assign base_r   = in_textured ? in_texel[14:10] : 5'd31;
    assign base_g   = in_textured ? in_texel[9:5]   : 5'd31;
    assign base_b   = in_textured ? in_texel[4:0]   : 5'd31;
    assign fog_sat  = in_fog_amount[8] ? rsb_pkg::FOG_FULL : in_fog_amount;
    assign dith_off = in_dither_on
                    ? rsb_pkg::dither_offset(rsb_pkg::bayer(in_y_low, in_x_low))
                    : 12'sd0;

    // per-channel math
    logic [4:0] new_r, new_g, new_b;

    rsb_shade_chan #(.SHADE_FRAC_BITS(SHADE_FRAC_BITS)) u_chan_r (
        .aclk(aclk), .en(chan_en), .base(base_r), .shade(in_shade_r),
        .fog_color(fog_r_reg), .fog_amt(fog_sat), .dith_off(dith_off), .chan(new_r)
    );

    rsb_shade_chan #(.SHADE_FRAC_BITS(SHADE_FRAC_BITS)) u_chan_g (
        .aclk(aclk), .en(chan_en), .base(base_g), .shade(in_shade_g),
        .fog_color(fog_g_reg), .fog_amt(fog_sat), .dith_off(dith_off), .chan(new_g)
    );

    rsb_shade_chan #(.SHADE_FRAC_BITS(SHADE_FRAC_BITS)) u_chan_b (
        .aclk(aclk), .en(chan_en), .base(base_b), .shade(in_shade_b),
        .fog_color(fog_b_reg), .fog_amt(fog_sat), .dith_off(dith_off), .chan(new_b)
    );

    // side band carried alongside the channel stages
    logic        we1_reg, we2_reg, we3_reg;
    logic [14:0] dest1_reg, dest2_reg, dest3_reg;
    logic [1:0]  mode1_reg, mode2_reg, mode3_reg;

    always_ff @(posedge aclk) begin
        if (en1) begin
            we1_reg   <= opaque;
            dest1_reg <= in_dest;
            mode1_reg <= in_mode;
        end
        if (en2) begin
            we2_reg   <= we1_reg;
            dest2_reg <= dest1_reg;
            mode2_reg <= mode1_reg;
        end
        if (en3) begin
            we3_reg   <= we2_reg;
            dest3_reg <= dest2_reg;
            mode3_reg <= mode2_reg;
        end
    end

    // stage 4: blend with destination
    logic [5:0]  sum_r, sum_g, sum_b;
    logic [14:0] blend_pix;
    logic        we4_reg;
    logic [14:0] pix4_reg;

    assign sum_r = {1'b0, new_r} + {1'b0, dest3_reg[14:10]};
    assign sum_g = {1'b0, new_g} + {1'b0, dest3_reg[9:5]};
    assign sum_b = {1'b0, new_b} + {1'b0, dest3_reg[4:0]};

    always_comb begin
        case (mode3_reg)
            rsb_pkg::BLEND_AVG: begin
                blend_pix = {sum_r[5:1], sum_g[5:1], sum_b[5:1]};
            end
            rsb_pkg::BLEND_ADD: begin
                blend_pix = {sum_r[5] ? 5'd31 : sum_r[4:0],
                             sum_g[5] ? 5'd31 : sum_g[4:0],
                             sum_b[5] ? 5'd31 : sum_b[4:0]};
            end
            default: begin
                blend_pix = {new_r, new_g, new_b};
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            we4_reg  <= we3_reg;
            pix4_reg <= we3_reg ? blend_pix : 15'd0;
        end
    end

    assign m_axis_tvalid = v4_reg;
    assign m_axis_tdata  = {pix4_reg, we4_reg};

endmodule

`default_nettype wire

>>> tb/rsb_pixel_checker.sv
// Watches both streams and the fog register port, predicts each pixel word
// and compares it with what comes out of the block, in order.
module rsb_pixel_checker #(
    parameter int SHADE_FRAC_BITS = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // texel[15:0], textured[16], shade_red[28:17], shade_green[40:29],
    // shade_blue[52:41], fog_amount[61:53], dither_on[62], x_low[64:63],
    // y_low[66:65], dest_pixel[81:67], blend_mode[83:82], zero[87:84]
    input  wire logic [87:0] s_axis_tdata,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    // write_enable[0], pixel[15:1]
    input  wire logic [15:0] m_axis_tdata,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [4:0]  cfg_data,
    output int               fail_count,
    output int               pending_count,
    output int               checked_count
);

    // one fragment word, first field in the low bits
    typedef struct packed {
        logic [3:0]  pad;
        logic [1:0]  blend_mode;
        logic [14:0] dest_pixel;
        logic [1:0]  y_low;
        logic [1:0]  x_low;
        logic        dither_on;
        logic [8:0]  fog_amount;
        logic [11:0] shade_blue;
        logic [11:0] shade_green;
        logic [11:0] shade_red;
        logic        textured;
        logic [15:0] texel;
    } frag_word_t;

    typedef struct packed {
        logic [14:0] pixel;
        logic        write_enable;
    } pix_word_t;

    // 4x4 ordered dither thresholds, nibble index {y, x}
    localparam logic [63:0] DITHER_NIBBLES = 64'h5D7F_91B3_6E4C_A280;

    logic [4:0] fog_r, fog_g, fog_b;
    pix_word_t  expected_pixels[$];

    // modulate by shade, lerp toward fog, dither, round and clamp to 5 bits
    function automatic logic [4:0] modulate_fog_round(input logic [4:0] base,
        input logic [11:0] shade, input logic [4:0] fog_c, input logic [8:0] famt,
        input logic dith, input logic [3:0] bay);
        longint v;
        v = longint'(base) * longint'(shade);
        if (SHADE_FRAC_BITS <= 4)
            v = v << (4 - SHADE_FRAC_BITS);
        else
            v = v >> (SHADE_FRAC_BITS - 4);
        if (famt != 0)
            v = (v * (256 - longint'(famt)) + longint'(fog_c) * 2048 * longint'(famt)) >>> 8;
        v = v + 1024;
        if (dith)
            v = v + longint'(bay) * 128 - 960;
        if (v < 0)
            return 5'd0;
        v = v >>> 11;
        return (v > 31) ? 5'd31 : v[4:0];
    endfunction

    function automatic logic [4:0] blend_chan(input logic [4:0] src, input logic [4:0] dst,
        input logic [1:0] mode);
        int sum;
        sum = int'(src) + int'(dst);
        case (mode)
            rsb_pkg::BLEND_AVG: return sum[5:1];
            rsb_pkg::BLEND_ADD: return (sum > 31) ? 5'd31 : sum[4:0];
            default:            return src;
        endcase
    endfunction

    function automatic pix_word_t predict_pixel(input frag_word_t f);
        logic [4:0] br, bg, bb, r, g, b;
        logic [8:0] famt;
        logic [3:0] bay;
        pix_word_t  res;
        famt = (f.fog_amount > rsb_pkg::FOG_FULL) ? rsb_pkg::FOG_FULL : f.fog_amount;
        bay  = DITHER_NIBBLES[{f.y_low, f.x_low} * 4 +: 4];
        {br, bg, bb} = {5'd31, 5'd31, 5'd31};
        if (f.textured) begin
            // transparent texel: no write, pixel zero
            if (!f.texel[15]) begin
                res = '0;
                return res;
            end
            {br, bg, bb} = f.texel[14:0];
        end
        r = modulate_fog_round(br, f.shade_red, fog_r, famt, f.dither_on, bay);
        g = modulate_fog_round(bg, f.shade_green, fog_g, famt, f.dither_on, bay);
        b = modulate_fog_round(bb, f.shade_blue, fog_b, famt, f.dither_on, bay);
        res.write_enable = 1'b1;
        res.pixel = {blend_chan(r, f.dest_pixel[14:10], f.blend_mode),
                     blend_chan(g, f.dest_pixel[9:5], f.blend_mode),
                     blend_chan(b, f.dest_pixel[4:0], f.blend_mode)};
        return res;
    endfunction

    initial begin
        fail_count    = 0;
        pending_count = 0;
        checked_count = 0;
    end

    // track fog registers, queue predictions, compare results in order
    always @(posedge aclk) begin
        pix_word_t exp_w;
        pix_word_t got_w;
        int        delta;
        delta = 0;
        if (!aresetn) begin
            fog_r <= 5'd0;
            fog_g <= 5'd0;
            fog_b <= 5'd0;
            expected_pixels.delete();
            pending_count <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    rsb_pkg::REG_FOG_RED:   fog_r <= cfg_data;
                    rsb_pkg::REG_FOG_GREEN: fog_g <= cfg_data;
                    rsb_pkg::REG_FOG_BLUE:  fog_b <= cfg_data;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got_w = m_axis_tdata;
                if (expected_pixels.size() == 0) begin
                    if (fail_count < 10)
                        $display("[%0t] unexpected result word %h", $realtime, m_axis_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_w = expected_pixels.pop_front();
                    delta = delta - 1;
                    checked_count <= checked_count + 1;
                    if (got_w.write_enable !== exp_w.write_enable ||
                        got_w.pixel !== exp_w.pixel) begin
                        if (fail_count < 10)
                            $display({"[%0t] mismatch: write_enable exp %b got %b,",
                                      " pixel exp %h got %h"},
                                     $realtime, exp_w.write_enable, got_w.write_enable,
                                     exp_w.pixel, got_w.pixel);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_pixels.insert(expected_pixels.size(), predict_pixel(s_axis_tdata));
                delta = delta + 1;
            end
            pending_count <= pending_count + delta;
        end
    end

endmodule

>>> tb/tb_rgb555_fragment_shade_blend.sv
// Stimulus and verdict; all prediction and checking lives in rsb_pixel_checker.
module tb_rgb555_fragment_shade_blend;

    localparam int         SHADE_FRAC_BITS = 4;
    localparam logic [1:0] BLEND_RSVD      = 2'd3;
    localparam int         RAND_PHASES     = 6;
    localparam int         RAND_PER_PHASE  = 242;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic [87:0] s_axis_tdata  = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [1:0]  cfg_index     = rsb_pkg::REG_FOG_RED;
    logic [4:0]  cfg_data      = '0;

    int fail_count, pending_count, checked_count;
    int frags_sent   = 0;
    int fog_settings = 0;
    int burst_left   = 0;
    int burst_max    = 8;
    int gap_max      = 4;
    int rx_mode      = 0;
    int stall_cnt    = 0;

    rgb555_fragment_shade_blend #(
        .SHADE_FRAC_BITS(SHADE_FRAC_BITS)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    rsb_pixel_checker #(
        .SHADE_FRAC_BITS(SHADE_FRAC_BITS)
    ) i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // hard stop
    initial begin
        #400000;
        $display("Verification failed");
        $finish;
    end

    // receiver back-pressure, pattern picked per phase
    always @(posedge aclk) begin
        stall_cnt <= stall_cnt + 1;
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 9) < 7);
            2:       m_axis_tready <= (stall_cnt[2:0] < 3'd5);
            default: m_axis_tready <= (stall_cnt[5:4] != 2'b11);
        endcase
    end

    // three back-to-back register writes, wr_en held high throughout
    task automatic set_fog_colour(input logic [4:0] r, input logic [4:0] g,
                                  input logic [4:0] b);
        cfg_wr_en <= 1'b1;
        cfg_index <= rsb_pkg::REG_FOG_RED;
        cfg_data  <= r;
        @(posedge aclk);
        cfg_index <= rsb_pkg::REG_FOG_GREEN;
        cfg_data  <= g;
        @(posedge aclk);
        cfg_index <= rsb_pkg::REG_FOG_BLUE;
        cfg_data  <= b;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        fog_settings++;
    endtask

    // present one fragment word, wait for accept, then maybe open a gap
    task automatic send_frag(input logic [15:0] texel, input logic textured,
        input logic [11:0] sr, input logic [11:0] sg, input logic [11:0] sb,
        input logic [8:0] famt, input logic dith, input logic [1:0] xl,
        input logic [1:0] yl, input logic [14:0] dest, input logic [1:0] mode);
        int gap;
        s_axis_tdata  <= {4'b0, mode, dest, yl, xl, dith, famt, sb, sg, sr, textured, texel};
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        frags_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, burst_max);
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // shade anywhere, near unity, or at the low and high ends
    function automatic logic [11:0] pick_shade();
        case ($urandom_range(0, 3))
            0:       return 12'($urandom);
            1:       return 12'($urandom_range(1792, 2303));
            2:       return 12'($urandom_range(0, 255));
            default: return 12'($urandom_range(3840, 4095));
        endcase
    endfunction

    task automatic send_random_frag();
        logic [15:0] texel;
        logic [8:0]  famt;
        int          pick;
        texel = 16'($urandom);
        if ($urandom_range(0, 7) != 0)
            texel[15] = 1'b1;
        pick = $urandom_range(0, 19);
        if (pick < 8)
            famt = 9'd0;
        else if (pick < 16)
            famt = 9'($urandom_range(1, 255));
        else if (pick < 18)
            famt = rsb_pkg::FOG_FULL;
        else
            famt = 9'($urandom_range(257, 511));
        send_frag(texel, ($urandom_range(0, 5) != 0), pick_shade(), pick_shade(),
                  pick_shade(), famt, 1'($urandom), 2'($urandom), 2'($urandom),
                  15'($urandom), 2'($urandom));
    endtask

    // drop valid, then wait until every predicted word has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed corners
        rx_mode = 1;
        set_fog_colour(5'd31, 5'd0, 5'd16);
        send_frag(16'h0000, 1'b0, 12'd2048, 12'd2048, 12'd2048, 9'd0, 1'b0, 2'd0, 2'd0,
                  15'h0000, rsb_pkg::BLEND_OPAQUE);
        send_frag(16'hFFFF, 1'b1, 12'd4095, 12'd4095, 12'd4095, 9'd0, 1'b0, 2'd1, 2'd1,
                  15'h7FFF, rsb_pkg::BLEND_OPAQUE);
        send_frag(16'h8000, 1'b1, 12'd4095, 12'd4095, 12'd4095, 9'd0, 1'b1, 2'd2, 2'd1,
                  15'h0000, rsb_pkg::BLEND_OPAQUE);
        // transparent texels
        send_frag(16'h7FFF, 1'b1, 12'd2048, 12'd2048, 12'd2048, 9'd0, 1'b1, 2'd3, 2'd3,
                  15'h7FFF, rsb_pkg::BLEND_ADD);
        send_frag(16'h0000, 1'b1, 12'd4095, 12'd0, 12'd4095, 9'd256, 1'b0, 2'd0, 2'd0,
                  15'h1234, rsb_pkg::BLEND_AVG);
        // untextured ignores the texel
        send_frag(16'h0000, 1'b0, 12'd1000, 12'd3000, 12'd2047, 9'd0, 1'b0, 2'd0, 2'd0,
                  15'h0000, rsb_pkg::BLEND_OPAQUE);
        send_frag(16'hFFFF, 1'b1, 12'd0, 12'd0, 12'd0, 9'd0, 1'b1, 2'd0, 2'd0,
                  15'h0000, rsb_pkg::BLEND_OPAQUE);
        // fog: full, saturated, just over full, half, minimal
        send_frag(16'hFFFF, 1'b1, 12'd2048, 12'd2048, 12'd2048, 9'd256, 1'b0, 2'd0, 2'd0,
                  15'h0000, rsb_pkg::BLEND_OPAQUE);
        send_frag(16'hFFFF, 1'b1, 12'd2048, 12'd2048, 12'd2048, 9'd511, 1'b0, 2'd0, 2'd0,
                  15'h0000, rsb_pkg::BLEND_OPAQUE);
        send_frag(16'hC210, 1'b1, 12'd2048, 12'd2048, 12'd2048, 9'd257, 1'b1, 2'd2, 2'd3,
                  15'h0000, rsb_pkg::BLEND_OPAQUE);
        send_frag(16'hA5A5, 1'b1, 12'd2048, 12'd2048, 12'd2048, 9'd128, 1'b0, 2'd0, 2'd0,
                  15'h0000, rsb_pkg::BLEND_OPAQUE);
        send_frag(16'hFFFF, 1'b1, 12'd4095, 12'd4095, 12'd4095, 9'd1, 1'b0, 2'd0, 2'd0,
                  15'h0000, rsb_pkg::BLEND_OPAQUE);
        // dither across the matrix, mid shade
        send_frag(16'h8842, 1'b1, 12'd1100, 12'd1100, 12'd1100, 9'd0, 1'b1, 2'd0, 2'd3,
                  15'h0000, rsb_pkg::BLEND_OPAQUE);
        send_frag(16'h8842, 1'b1, 12'd1100, 12'd1100, 12'd1100, 9'd0, 1'b1, 2'd3, 2'd0,
                  15'h0000, rsb_pkg::BLEND_OPAQUE);
        send_frag(16'h8842, 1'b1, 12'd1100, 12'd1100, 12'd1100, 9'd0, 1'b1, 2'd2, 2'd2,
                  15'h0000, rsb_pkg::BLEND_OPAQUE);
        send_frag(16'h8842, 1'b1, 12'd1100, 12'd1100, 12'd1100, 9'd0, 1'b1, 2'd1, 2'd2,
                  15'h0000, rsb_pkg::BLEND_OPAQUE);
        send_frag(16'h8421, 1'b1, 12'd1, 12'd1, 12'd1, 9'd0, 1'b1, 2'd2, 2'd0,
                  15'h0000, rsb_pkg::BLEND_OPAQUE);
        // blend modes against extreme destinations
        send_frag(16'hFFFF, 1'b1, 12'd2048, 12'd2048, 12'd2048, 9'd0, 1'b0, 2'd0, 2'd0,
                  15'h7FFF, rsb_pkg::BLEND_AVG);
        send_frag(16'h8000, 1'b1, 12'd2048, 12'd2048, 12'd2048, 9'd0, 1'b0, 2'd0, 2'd0,
                  15'h7FFF, rsb_pkg::BLEND_AVG);
        send_frag(16'hBDEF, 1'b1, 12'd2048, 12'd2048, 12'd2048, 9'd0, 1'b0, 2'd0, 2'd0,
                  15'h7FFF, rsb_pkg::BLEND_ADD);
        send_frag(16'hBDEF, 1'b1, 12'd2048, 12'd2048, 12'd2048, 9'd0, 1'b0, 2'd0, 2'd0,
                  15'h0000, rsb_pkg::BLEND_ADD);
        send_frag(16'hBDEF, 1'b1, 12'd2048, 12'd2048, 12'd2048, 9'd0, 1'b1, 2'd1, 2'd3,
                  15'h7FFF, BLEND_RSVD);
        send_frag(16'h0000, 1'b0, 12'd4095, 12'd2048, 12'd0, 9'd64, 1'b1, 2'd3, 2'd1,
                  15'h4210, rsb_pkg::BLEND_ADD);
        drain();

        // random phases: fog colour, receiver pattern and gap style change each time
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0:       set_fog_colour(5'd0, 5'd0, 5'd0);
                1:       set_fog_colour(5'd31, 5'd31, 5'd31);
                default: set_fog_colour(5'($urandom), 5'($urandom), 5'($urandom));
            endcase
            rx_mode   = ph % 4;
            burst_max = (ph == 2) ? 1000 : $urandom_range(1, 12);
            gap_max   = (ph == 2) ? 0 : $urandom_range(1, 6);
            for (int n = 0; n < RAND_PER_PHASE; n++)
                send_random_frag();
            drain();
        end

        repeat (20) @(posedge aclk);
        $display("Sent %0d fragments under %0d fog colours; %0d result words checked",
                 frags_sent, fog_settings, checked_count);
        if (fail_count == 0 && pending_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
